[rtl/core/spqdk_pkg.sv]
// shared op codes, status codes and field widths for the sorted priority queue
package spqdk_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_DECKEY = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int FIELD_BITS = 16;
   localparam int OCC_BITS   = 5;

endpackage

[rtl/core/spqdk_mem.sv]
// entry storage: one synchronous memory, one write and one registered read port
module spqdk_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sorted_priority_queue_decrease_key.sv]
// sorted priority queue: one operation walks the entry memory slot by slot
// clear and the error cases go straight to the result; pop, insert and decrease-key
//   shift entries, bounded by the entry memory's single read and single write port
//   (each slot move first reads the slot, then writes it into its neighbour)
// throughput: one operation at a time; the next is taken once the queue is idle and the result register is free
// reset: synchronous, active high; empties the queue, memory contents are left as they are
module sorted_priority_queue_decrease_key
   import spqdk_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int TAG_BITS  = 16,
   parameter int PRIO_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [FIELD_BITS-1:0] req_tag,
   input  logic [FIELD_BITS-1:0] req_prio,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [FIELD_BITS-1:0] rsp_popped_tag,
   output logic [FIELD_BITS-1:0] rsp_front_tag,
   output logic [FIELD_BITS-1:0] rsp_front_prio,
   output logic [OCC_BITS-1:0]   rsp_occupancy,
   output logic                  rsp_empty_flag
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = TAG_BITS + PRIO_BITS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,  // read slot, look for match or insert point
      S_LEFT  = 7'b0000100,  // shift entries down one (removal)
      S_RIGHT = 7'b0001000,  // shift entries up one (insertion)
      S_PLACE = 7'b0010000,
      S_FRONT = 7'b0100000,  // read slot zero for the result
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // slot currently addressed
   logic [CW-1:0] pos_ff, pos_in;     // removal slot / insertion slot
   logic phase_ff, phase_in;          // 0 address issued, 1 data back
   logic dk_ff, dk_in;                // decrease-key, removal done, insert pending
   logic [1:0] status_ff, status_in;
   logic [TAG_BITS-1:0] popped_ff, popped_in;
   logic rv_ff, rv_in;
   logic [1:0] rs_ff, rs_in;
   logic [FIELD_BITS-1:0] rpop_ff, rpop_in, rft_ff, rft_in, rfp_ff, rfp_in;
   logic [OCC_BITS-1:0] rocc_ff, rocc_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [TAG_BITS-1:0] rd_tag;
   logic [PRIO_BITS-1:0] rd_prio;

   spqdk_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_tag  = rd_data[EW-1:PRIO_BITS];
   assign rd_prio = rd_data[PRIO_BITS-1:0];

   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);

   always_comb begin
      state_in = state_ff; op_in = op_ff; tag_in = tag_ff; prio_in = prio_ff;
      count_in = count_ff; idx_in = idx_ff; pos_in = pos_ff; phase_in = phase_ff;
      dk_in = dk_ff; status_in = status_ff; popped_in = popped_ff;
      rv_in = rv_ff && rsp_stall; rs_in = rs_ff; rpop_in = rpop_ff; rft_in = rft_ff;
      rfp_in = rfp_ff; rocc_in = rocc_ff;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in = req_op;
               tag_in = req_tag[TAG_BITS-1:0];
               prio_in = req_prio[PRIO_BITS-1:0];
               status_in = ST_OK; popped_in = '0; dk_in = 1'b0;
               idx_in = '0; phase_in = 1'b0;
               case (req_op)
                  OP_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_FULL; state_in = S_FRONT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; state_in = S_FRONT;
                     end else begin
                        pos_in = '0; state_in = S_SCAN;
                     end
                  end
                  OP_DECKEY: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; state_in = S_FRONT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     count_in = '0; state_in = S_FRONT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!phase_ff) begin
               if (idx_ff == count_ff) begin
                  // ran off the end
                  if (op_ff == OP_DECKEY && !dk_ff) begin
                     status_in = ST_NOMATCH; state_in = S_FRONT;
                  end else begin
                     pos_in = idx_ff; idx_in = count_ff; state_in = S_RIGHT;
                  end
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               if (op_ff == OP_POP) begin
                  popped_in = rd_tag; pos_in = '0; idx_in = '0; state_in = S_LEFT;
               end else if (op_ff == OP_DECKEY && !dk_ff) begin
                  if (rd_tag == tag_ff && rd_prio > prio_ff) begin
                     pos_in = idx_ff; state_in = S_LEFT;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end else if (rd_prio > prio_ff) begin
                  pos_in = idx_ff; idx_in = count_ff; state_in = S_RIGHT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_LEFT: begin
            // move slot idx+1 into idx until the tail
            if (!phase_ff) begin
               if (idx_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  if (op_ff == OP_DECKEY) begin
                     dk_in = 1'b1; idx_in = '0; state_in = S_SCAN;
                  end else begin
                     state_in = S_FRONT;
                  end
               end else begin
                  rd_addr = AW'(idx_ff + 1'b1); phase_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
               idx_in = idx_ff + 1'b1; phase_in = 1'b0;
            end
         end
         S_RIGHT: begin
            // move slot idx-1 into idx down to the insertion slot
            if (!phase_ff) begin
               if (idx_ff == pos_ff) begin
                  state_in = S_PLACE;
               end else begin
                  rd_addr = AW'(idx_ff - 1'b1); phase_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
               idx_in = idx_ff - 1'b1; phase_in = 1'b0;
            end
         end
         S_PLACE: begin
            wr_en = 1'b1; wr_addr = pos_ff[AW-1:0]; wr_data = {tag_ff, prio_ff};
            count_in = count_ff + 1'b1; state_in = S_FRONT;
         end
         S_FRONT: begin
            rd_addr = '0; state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; rs_in = status_ff;
               rpop_in = FIELD_BITS'(popped_ff);
               rft_in = (count_ff == '0) ? '0 : FIELD_BITS'(rd_tag);
               rfp_in = (count_ff == '0) ? '0 : FIELD_BITS'(rd_prio);
               rocc_in = OCC_BITS'(count_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rv_ff <= 1'b0;
         phase_ff <= 1'b0; dk_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         phase_ff <= phase_in; dk_ff <= dk_in;
      end
      op_ff <= op_in; tag_ff <= tag_in; prio_ff <= prio_in; idx_ff <= idx_in;
      pos_ff <= pos_in; status_ff <= status_in; popped_ff <= popped_in;
      rs_ff <= rs_in; rpop_ff <= rpop_in; rft_ff <= rft_in; rfp_ff <= rfp_in;
      rocc_ff <= rocc_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_popped_tag = rpop_ff;
   assign rsp_front_tag  = rft_ff;
   assign rsp_front_prio = rfp_ff;
   assign rsp_occupancy  = rocc_ff;
   assign rsp_empty_flag = (rocc_ff == '0);

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the sorted priority queue with decrease-key
`timescale 1ns / 1ps

module tb_top
   import spqdk_pkg::*;
();

   localparam int QDEPTH = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM = 1800;

   typedef struct packed {
      logic [1:0]            op;
      logic [FIELD_BITS-1:0] tag;
      logic [FIELD_BITS-1:0] prio;
   } op_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [FIELD_BITS-1:0] popped_tag;
      logic [FIELD_BITS-1:0] front_tag;
      logic [FIELD_BITS-1:0] front_prio;
      logic [OCC_BITS-1:0]   occupancy;
      logic                  empty_flag;
   } queue_rsp_type;

   // directed row: request plus optional typed-in result
   typedef struct packed {
      op_req_type    rq;
      logic          typed;
      queue_rsp_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = OP_INSERT;
   logic [FIELD_BITS-1:0] req_tag = '0;
   logic [FIELD_BITS-1:0] req_prio = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [FIELD_BITS-1:0] rsp_popped_tag, rsp_front_tag, rsp_front_prio;
   logic [OCC_BITS-1:0] rsp_occupancy;
   logic rsp_empty_flag;

   sorted_priority_queue_decrease_key u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the queue contents
   logic [FIELD_BITS-1:0] shadow_tag [QDEPTH];
   logic [FIELD_BITS-1:0] shadow_prio [QDEPTH];
   int shadow_count = 0;

   queue_rsp_type pending_rsp [$];
   int errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   int op_seen [4] = '{0, 0, 0, 0};
   int st_seen [4] = '{0, 0, 0, 0};
   bit stim_done = 1'b0;
   bit hold_request = 1'b0;

   function automatic int first_above(logic [FIELD_BITS-1:0] p);
      int i;
      i = 0;
      while (i < shadow_count && shadow_prio[i] <= p) i++;
      return i;
   endfunction

   function automatic void shadow_insert(int pos, logic [FIELD_BITS-1:0] t,
                                         logic [FIELD_BITS-1:0] p);
      for (int i = shadow_count; i > pos; i--) begin
         shadow_tag[i] = shadow_tag[i-1];
         shadow_prio[i] = shadow_prio[i-1];
      end
      shadow_tag[pos] = t;
      shadow_prio[pos] = p;
      shadow_count++;
   endfunction

   function automatic void shadow_remove(int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_tag[i] = shadow_tag[i+1];
         shadow_prio[i] = shadow_prio[i+1];
      end
      shadow_count--;
   endfunction

   function automatic queue_rsp_type apply_queue_op(op_req_type rq);
      queue_rsp_type r;
      int hit;
      r = '0;
      r.status = ST_OK;
      case (rq.op)
         OP_INSERT: begin
            if (shadow_count >= QDEPTH) r.status = ST_FULL;
            else shadow_insert(first_above(rq.prio), rq.tag, rq.prio);
         end
         OP_POP: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
               r.popped_tag = shadow_tag[0];
               shadow_remove(0);
            end
         end
         OP_DECKEY: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
               hit = -1;
               for (int i = 0; i < shadow_count; i++)
                  if (hit < 0 && shadow_tag[i] == rq.tag && shadow_prio[i] > rq.prio)
                     hit = i;
               if (hit < 0) r.status = ST_NOMATCH;
               else begin
                  shadow_remove(hit);
                  shadow_insert(first_above(rq.prio), rq.tag, rq.prio);
               end
            end
         end
         default: shadow_count = 0;
      endcase
      if (shadow_count > 0) begin
         r.front_tag = shadow_tag[0];
         r.front_prio = shadow_prio[0];
      end
      r.occupancy = OCC_BITS'(shadow_count);
      r.empty_flag = (shadow_count == 0);
      return r;
   endfunction

   // offer one transaction, hold until accepted
   task automatic send_req(op_req_type rq);
      req_op <= rq.op;
      req_tag <= rq.tag;
      req_prio <= rq.prio;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // predictor runs at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_rsp.push_back(apply_queue_op('{req_op, req_tag, req_prio}));
         op_seen[req_op]++;
         n_accepted++;
      end
   end

   always @(posedge clock) begin
      queue_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result with nothing outstanding");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            st_seen[rsp_status]++;
            if (rsp_status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_status); errors++;
            end
            if (rsp_popped_tag !== want.popped_tag) begin
               $error("popped_tag exp %0h got %0h", want.popped_tag, rsp_popped_tag);
               errors++;
            end
            if (rsp_front_tag !== want.front_tag) begin
               $error("front_tag exp %0h got %0h", want.front_tag, rsp_front_tag); errors++;
            end
            if (rsp_front_prio !== want.front_prio) begin
               $error("front_prio exp %0h got %0h", want.front_prio, rsp_front_prio);
               errors++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy exp %0d got %0d", want.occupancy, rsp_occupancy); errors++;
            end
            if (rsp_empty_flag !== want.empty_flag) begin
               $error("empty_flag exp %0b got %0b", want.empty_flag, rsp_empty_flag);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      int hold;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            hold = 300 + $urandom_range(0, 100);
            repeat (hold) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic op_req_type mk(logic [1:0] o, int t, int p);
      op_req_type rq;
      rq.op = o;
      rq.tag = FIELD_BITS'(t);
      rq.prio = FIELD_BITS'(p);
      return rq;
   endfunction

   function automatic queue_rsp_type mkr(logic [1:0] s, int pt, int ft, int fp, int occ);
      queue_rsp_type r;
      r.status = s;
      r.popped_tag = FIELD_BITS'(pt);
      r.front_tag = FIELD_BITS'(ft);
      r.front_prio = FIELD_BITS'(fp);
      r.occupancy = OCC_BITS'(occ);
      r.empty_flag = (occ == 0);
      return r;
   endfunction

   // typed-in rows: keep a copy of the last accepted result and compare it with the typed value
   logic [FIELD_BITS-1:0] last_front_tag, last_front_prio;
   logic [OCC_BITS-1:0] last_occ;
   logic [1:0] last_status;
   logic [FIELD_BITS-1:0] last_popped;
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) begin
         last_status <= rsp_status;
         last_popped <= rsp_popped_tag;
         last_front_tag <= rsp_front_tag;
         last_front_prio <= rsp_front_prio;
         last_occ <= rsp_occupancy;
      end

   function automatic queue_rsp_type apply_check_copy(dir_row_type row);
      queue_rsp_type seen;
      seen = mkr(last_status, last_popped, last_front_tag, last_front_prio, last_occ);
      if (seen !== row.want) begin
         $error("directed result exp %0h got %0h", row.want, seen);
         errors++;
      end
      return seen;
   endfunction

   initial begin
      dir_row_type dir_rows [$];
      op_req_type rq;
      int burst;
      int r;
      int tag_pool [8];
      int drain;
      int gap;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty-queue cases, extremes, FIFO ties, decrease-key forms
      dir_rows.push_back('{mk(OP_POP, 0, 0), 1'b1, mkr(ST_EMPTY, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_DECKEY, 5, 0), 1'b1, mkr(ST_EMPTY, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_CLEAR, 0, 0), 1'b1, mkr(ST_OK, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_INSERT, 16'hFFFF, 16'hFFFF), 1'b1,
                           mkr(ST_OK, 0, 16'hFFFF, 16'hFFFF, 1)});
      dir_rows.push_back('{mk(OP_INSERT, 0, 0), 1'b1, mkr(ST_OK, 0, 0, 0, 2)});
      dir_rows.push_back('{mk(OP_INSERT, 7, 0), 1'b0, '0});
      dir_rows.push_back('{mk(OP_INSERT, 9, 100), 1'b0, '0});
      dir_rows.push_back('{mk(OP_DECKEY, 9, 100), 1'b0, '0});
      dir_rows.push_back('{mk(OP_DECKEY, 1234, 1), 1'b0, '0});
      dir_rows.push_back('{mk(OP_DECKEY, 16'hFFFF, 0), 1'b0, '0});
      dir_rows.push_back('{mk(OP_POP, 0, 0), 1'b1, mkr(ST_OK, 0, 7, 0, 3)});
      dir_rows.push_back('{mk(OP_POP, 0, 0), 1'b0, '0});
      for (int i = 0; i < 15; i++)
         dir_rows.push_back('{mk(OP_INSERT, 16'h5555 ^ i, 16'hAAAA ^ i), 1'b0, '0});
      dir_rows.push_back('{mk(OP_INSERT, 1, 1), 1'b0, '0});
      dir_rows.push_back('{mk(OP_INSERT, 2, 2), 1'b0, '0});
      dir_rows.push_back('{mk(OP_CLEAR, 0, 0), 1'b1, mkr(ST_OK, 0, 0, 0, 0)});

      foreach (dir_rows[k]) begin
         send_req(dir_rows[k].rq);
         if (dir_rows[k].typed) begin
            req_valid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
            // predictor already checks; also hold the typed value against it
            void'(apply_check_copy(dir_rows[k]));
         end
      end

      // random part: bursts of well-formed traffic on a small tag pool
      for (int i = 0; i < 8; i++) tag_pool[i] = $urandom_range(0, 16'hFFFF);
      for (int n = 0; n < N_RANDOM; ) begin
         if (n > 600 && n < 610) hold_request = 1'b1;
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) rq = mk(OP_INSERT, tag_pool[$urandom_range(0, 7)],
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                            : $urandom_range(0, 40));
            else if (r < 75) rq = mk(OP_POP, $urandom, $urandom);
            else if (r < 97) rq = mk(OP_DECKEY, ($urandom_range(0, 9) == 0) ? $urandom
                                     : tag_pool[$urandom_range(0, 7)], $urandom_range(0, 40));
            else rq = mk(OP_CLEAR, $urandom, $urandom);
            send_req(rq);
         end
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;

      drain = 0;
      while (pending_rsp.size() != 0 && drain < 50000) begin
         @(negedge clock);
         drain++;
      end
      repeat (2 * QDEPTH + 10) @(negedge clock);

      $display("covered %0d transactions: insert %0d, pop %0d, decrease-key %0d, clear %0d",
               n_accepted, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("status mix ok %0d, empty %0d, no match %0d, full %0d; %0d results checked",
               st_seen[0], st_seen[1], st_seen[2], st_seen[3], n_checked);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
